### hdl/sqe_pkg.sv
`timescale 1ns / 1ps
package sqe_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CODE_W = 3;

  typedef enum logic [CODE_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_DUMP = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_POP  = 3'd3,
    CMD_SWAP = 3'd4
  } cmd_code_e;

  typedef enum logic [CODE_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FEW    = 3'd2,
    ST_FULL   = 3'd3,
    ST_NODATA = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_FRONT,
    RD_SECOND,
    RD_NEXT
  } rd_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_SWAP_A,
    WR_SWAP_B
  } wr_op_e;

  typedef enum logic [1:0] {
    PTR_NONE,
    PTR_PUSH,
    PTR_POP
  } ptr_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    rd_op_e  rd_op;
    wr_op_e  wr_op;
    ptr_op_e ptr_op;
    logic    tmp_ld;
    logic    out_ld;
    logic    out_ram;
    status_e out_status;
    logic    out_last;
  } sqe_ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic empty;
    logic fewer_two;
    logic full;
    logic dump_last;
    logic out_free;
  } sqe_sts_t;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
  endfunction

  // Front plus an offset below the depth, wrapped once.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] front,
                                                input logic [CNT_W-1:0] offs);
    logic [IDX_W+1:0] sum;
    sum = (IDX_W+2)'(front) + (IDX_W+2)'(offs);
    if (sum >= (IDX_W+2)'(DEPTH)) begin
      sum = sum - (IDX_W+2)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### hdl/sqe_if.sv
`timescale 1ns / 1ps
interface sqe_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [sqe_pkg::CODE_W-1:0]  command;
  logic signed [sqe_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

interface sqe_res_if;
  logic                        valid;
  logic                        ready;
  logic signed [sqe_pkg::DATA_W-1:0] data_value;
  logic [sqe_pkg::CODE_W-1:0]  status;
  logic                        last;

  modport source (output valid, output data_value, output status, output last,
                  input ready);
  modport sink (input valid, input data_value, input status, input last,
                output ready);
endinterface

interface sqe_cfg_if;
  logic valid;
  logic ready;
  logic queue_mode;

  modport source (output valid, output queue_mode, input ready);
  modport sink (input valid, input queue_mode, output ready);
endinterface

### hdl/sqe_ram.sv
`timescale 1ns / 1ps
module sqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sqe_ctrl.sv
`timescale 1ns / 1ps
module sqe_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  logic [sqe_pkg::CODE_W-1:0] cmd_code_i,
  output logic                       cmd_ready_o,
  input  sqe_pkg::sqe_sts_t          sts_i,
  output sqe_pkg::sqe_ctrl_t         ctrl_o
);
  import sqe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PEEK = 3'd1;
  localparam logic [2:0] S_DUMP = 3'd2;
  localparam logic [2:0] S_SW1  = 3'd3;
  localparam logic [2:0] S_SW2  = 3'd4;
  localparam logic [2:0] S_SW3  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign cmd_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d           = state_q;
    ctrl_o.rd_op      = RD_NONE;
    ctrl_o.wr_op      = WR_NONE;
    ctrl_o.ptr_op     = PTR_NONE;
    ctrl_o.tmp_ld     = 1'b0;
    ctrl_o.out_ld     = 1'b0;
    ctrl_o.out_ram    = 1'b0;
    ctrl_o.out_status = ST_OK;
    ctrl_o.out_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_code_i)
            CMD_PUSH: begin
              ctrl_o.out_ld = 1'b1;
              if (sts_i.full) begin
                ctrl_o.out_status = ST_FULL;
              end else begin
                ctrl_o.wr_op  = WR_PUSH;
                ctrl_o.ptr_op = PTR_PUSH;
              end
            end
            CMD_DUMP: begin
              if (sts_i.empty) begin
                ctrl_o.out_ld     = 1'b1;
                ctrl_o.out_status = ST_NODATA;
              end else begin
                ctrl_o.rd_op = RD_FRONT;
                state_d      = S_DUMP;
              end
            end
            CMD_PEEK: begin
              if (sts_i.empty) begin
                ctrl_o.out_ld     = 1'b1;
                ctrl_o.out_status = ST_EMPTY;
              end else begin
                ctrl_o.rd_op = RD_FRONT;
                state_d      = S_PEEK;
              end
            end
            CMD_POP: begin
              ctrl_o.out_ld = 1'b1;
              if (sts_i.empty) begin
                ctrl_o.out_status = ST_EMPTY;
              end else begin
                ctrl_o.ptr_op = PTR_POP;
              end
            end
            CMD_SWAP: begin
              if (sts_i.fewer_two) begin
                ctrl_o.out_ld     = 1'b1;
                ctrl_o.out_status = ST_FEW;
              end else begin
                ctrl_o.rd_op = RD_FRONT;
                state_d      = S_SW1;
              end
            end
            default: begin
              // Unused codes are taken and dropped without a result.
            end
          endcase
        end
      end
      S_PEEK: begin
        if (sts_i.out_free) begin
          ctrl_o.out_ld  = 1'b1;
          ctrl_o.out_ram = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DUMP: begin
        // The read of the next entry is issued only when the current one
        // leaves, so a stalled result keeps its read data.
        if (sts_i.out_free) begin
          ctrl_o.out_ld   = 1'b1;
          ctrl_o.out_ram  = 1'b1;
          ctrl_o.out_last = sts_i.dump_last;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            ctrl_o.rd_op = RD_NEXT;
          end
        end
      end
      S_SW1: begin
        ctrl_o.tmp_ld = 1'b1;
        ctrl_o.rd_op  = RD_SECOND;
        state_d       = S_SW2;
      end
      S_SW2: begin
        ctrl_o.wr_op = WR_SWAP_A;
        state_d      = S_SW3;
      end
      S_SW3: begin
        if (sts_i.out_free) begin
          ctrl_o.wr_op  = WR_SWAP_B;
          ctrl_o.out_ld = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/sqe_dp.sv
`timescale 1ns / 1ps
module sqe_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [sqe_pkg::DATA_W-1:0] push_value_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_queue_mode_i,
  input  sqe_pkg::sqe_ctrl_t                ctrl_i,
  output sqe_pkg::sqe_sts_t                 sts_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic signed [sqe_pkg::DATA_W-1:0] res_data_o,
  output logic [sqe_pkg::CODE_W-1:0]        res_status_o,
  output logic                              res_last_o
);
  import sqe_pkg::*;

  logic                queue_mode_q;
  logic [IDX_W-1:0]    front_q, front_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    nslot_q, nslot_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [DATA_W-1:0]   tmp_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_data_q;
  logic [CODE_W-1:0]   out_status_q;
  logic                out_last_q;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  sqe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.fewer_two = (count_q < CNT_W'(2));
  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.dump_last = ((pos_q + CNT_W'(1)) == count_q);
  assign sts_o.out_free  = !out_valid_q || res_ready_i;

  // Read side: the front, the entry behind it, or the next entry of a dump.
  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = front_q;
    nslot_d   = nslot_q;
    pos_d     = pos_q;
    case (ctrl_i.rd_op)
      RD_FRONT: begin
        nslot_d = slot_inc(front_q);
        pos_d   = '0;
      end
      RD_SECOND: begin
        ram_raddr = slot_inc(front_q);
      end
      RD_NEXT: begin
        ram_raddr = nslot_q;
        nslot_d   = slot_inc(nslot_q);
        pos_d     = pos_q + CNT_W'(1);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = front_q;
    ram_wdata = ram_rdata;
    case (ctrl_i.wr_op)
      WR_PUSH: begin
        ram_waddr = queue_mode_q ? slot_add(front_q, count_q) : slot_dec(front_q);
        ram_wdata = push_value_i;
      end
      WR_SWAP_A: begin
        ram_waddr = front_q;
        ram_wdata = ram_rdata;
      end
      WR_SWAP_B: begin
        ram_waddr = slot_inc(front_q);
        ram_wdata = tmp_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    case (ctrl_i.ptr_op)
      PTR_PUSH: begin
        count_d = count_q + CNT_W'(1);
        if (!queue_mode_q) begin
          front_d = slot_dec(front_q);
        end
      end
      PTR_POP: begin
        count_d = count_q - CNT_W'(1);
        front_d = slot_inc(front_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mode_q <= 1'b0;
      front_q      <= '0;
      count_q      <= '0;
      nslot_q      <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        queue_mode_q <= cfg_queue_mode_i;
      end
      front_q <= front_d;
      count_q <= count_d;
      nslot_q <= nslot_d;
      pos_q   <= pos_d;
      if (ctrl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tmp_ld) begin
      tmp_q <= ram_rdata;
    end
    if (ctrl_i.out_ld) begin
      out_data_q   <= ctrl_i.out_ram ? ram_rdata : '0;
      out_status_q <= ctrl_i.out_status;
      out_last_q   <= ctrl_i.out_last;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_data_o   = out_data_q;
  assign res_status_o = out_status_q;
  assign res_last_o   = out_last_q;

endmodule

### hdl/stack_queue_engine_unit.sv
`timescale 1ns / 1ps
// Bounded stack or queue of up to DEPTH signed 32-bit entries, held in a
// single RAM with one write and one registered read port. Each command item
// is taken only while the engine is idle and its result register is free or
// being emptied. Push, pop and any refused command give their one result in
// the cycle after the item is taken; peek reads the front and then loads it
// as its result, swap does two reads and two writes through the single RAM
// port pair, and dump gives one entry per cycle while results are taken at
// once, holding while a result waits. Codes five to seven are taken and
// produce no result. The RAM has no reset and needs no clearing pass, as only
// live entries are ever read. queue_mode may be written at any time the block
// is idle; it selects pushing at the back instead of the front.
module stack_queue_engine_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  sqe_cmd_if.sink  cmd_i,
  sqe_res_if.source res_o,
  sqe_cfg_if.sink  cfg_i
);
  import sqe_pkg::*;

  sqe_ctrl_t ctrl;
  sqe_sts_t  sts;
  logic      cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  sqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_i.valid),
    .cmd_code_i (cmd_i.command),
    .cmd_ready_o(cmd_i.ready),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  sqe_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_value_i    (cmd_i.push_value),
    .cfg_we_i        (cfg_we),
    .cfg_queue_mode_i(cfg_i.queue_mode),
    .ctrl_i          (ctrl),
    .sts_o           (sts),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .res_data_o      (res_o.data_value),
    .res_status_o    (res_o.status),
    .res_last_o      (res_o.last)
  );

endmodule
